FILE: rtl/nud_pkg.sv
// ----------------------------------------------------------------------------
// nud_pkg
// Shared types and constants for the NAL unit deframer.
// ----------------------------------------------------------------------------
package nud_pkg;

    localparam logic [7:0] EMU_PREVENT_BYTE = 8'h03;

    localparam logic [4:0] NAL_TYPE_PREFIX    = 5'd14;
    localparam logic [4:0] NAL_TYPE_SVC_EXT   = 5'd20;
    localparam logic [4:0] NAL_TYPE_3DAVC_EXT = 5'd21;

    localparam logic [2:0] HDR_LEN_BASE   = 3'd1;
    localparam logic [2:0] HDR_LEN_3DAVC  = 3'd3;
    localparam logic [2:0] HDR_LEN_EXT    = 3'd4;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    typedef struct packed {
        logic       extension_flag;
        logic [2:0] header_length;
        logic       forbidden_bit;
        logic [4:0] unit_type;
        logic [1:0] ref_idc;
    } hdr_info_t;

    typedef struct packed {
        hdr_info_t  info;
        logic       payload_last;
        logic [7:0] payload_byte;
    } result_t;

endpackage

FILE: rtl/nal_unit_deframer_unit.sv
// ----------------------------------------------------------------------------
// nal_unit_deframer_unit
// Strips the header of an H.264 NAL unit and removes emulation prevention
// bytes from its payload, marking the final payload byte.
// ----------------------------------------------------------------------------
// Takes one byte per cycle on the slave side; s_tlast marks the final byte of
// a NAL unit. Each byte is parsed in the cycle it is accepted and its results
// go into a four-entry result queue that drives the master side, so a new
// byte is taken every cycle while the queue holds two results or fewer. A unit
// ending on a kept byte while another is held back yields two results from
// one byte; every unit starts with at least one header byte that yields none,
// so the queue drains and the sustained rate stays at one byte per cycle with
// an idle master side only when m_tready is low. Results carry the unit's
// header fields in m_tuser; a unit ending inside its header yields no result.
module nal_unit_deframer_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // unit_end

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] payload_byte
    output logic        m_tlast,   // payload_last
    output logic [11:0] m_tuser    // [1:0] ref_idc, [6:2] unit_type, [7] forbidden_bit,
                                   // [10:8] header_length, [11] extension_flag
);

    logic [2:0] byte_pos_reg,   byte_pos_next;
    logic [2:0] hdr_size_reg,   hdr_size_next;
    logic [1:0] zero_run_reg,   zero_run_next;
    logic [7:0] held_byte_reg,  held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] hdr_byte_reg,   hdr_byte_next;
    logic       ext_bit_reg,    ext_bit_next;

    nud_pkg::result_t               queue_mem [nud_pkg::QUEUE_DEPTH];
    logic [nud_pkg::QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [nud_pkg::QUEUE_AW:0]     count_reg,  count_next;

    logic       in_acc, out_acc;
    logic       in_payload, keep;
    logic       push_a, push_b;
    logic [1:0] push_cnt;
    nud_pkg::hdr_info_t info;
    nud_pkg::result_t   res_a, res_b;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (count_reg <= (nud_pkg::QUEUE_AW + 1)'(nud_pkg::QUEUE_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);

    assign in_payload = (byte_pos_reg >= hdr_size_reg);
    assign keep       = !((zero_run_reg == 2'd2) && (s_tdata == nud_pkg::EMU_PREVENT_BYTE));

    assign info.ref_idc        = hdr_byte_reg[6:5];
    assign info.unit_type      = hdr_byte_reg[4:0];
    assign info.forbidden_bit  = hdr_byte_reg[7];
    assign info.header_length  = hdr_size_reg;
    assign info.extension_flag = ext_bit_reg;

    assign push_a = in_acc && in_payload &&
                    ((held_valid_reg && (keep || s_tlast)) ||
                     (!held_valid_reg && keep && s_tlast));
    assign push_b = in_acc && in_payload && held_valid_reg && keep && s_tlast;
    assign push_cnt = {1'b0, push_a} + {1'b0, push_b};

    always_comb begin
        res_a.info         = info;
        res_a.payload_byte = held_valid_reg ? held_byte_reg : s_tdata;
        res_a.payload_last = held_valid_reg ? !keep : 1'b1;
        res_b.info         = info;
        res_b.payload_byte = s_tdata;
        res_b.payload_last = 1'b1;
    end

    always_comb begin
        byte_pos_next   = byte_pos_reg;
        hdr_size_next   = hdr_size_reg;
        zero_run_next   = zero_run_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        hdr_byte_next   = hdr_byte_reg;
        ext_bit_next    = ext_bit_reg;
        if (in_acc) begin
            if (!in_payload) begin
                if (byte_pos_reg == 3'd0) begin
                    hdr_byte_next = s_tdata;
                    ext_bit_next  = 1'b0;
                    if ((s_tdata[4:0] == nud_pkg::NAL_TYPE_PREFIX) ||
                        (s_tdata[4:0] == nud_pkg::NAL_TYPE_SVC_EXT) ||
                        (s_tdata[4:0] == nud_pkg::NAL_TYPE_3DAVC_EXT)) begin
                        hdr_size_next = nud_pkg::HDR_LEN_EXT;
                    end else begin
                        hdr_size_next = nud_pkg::HDR_LEN_BASE;
                    end
                end else if (byte_pos_reg == 3'd1) begin
                    ext_bit_next = s_tdata[7];
                    if ((hdr_byte_reg[4:0] == nud_pkg::NAL_TYPE_3DAVC_EXT) && s_tdata[7]) begin
                        hdr_size_next = nud_pkg::HDR_LEN_3DAVC;
                    end
                end
                byte_pos_next = byte_pos_reg + 3'd1;
            end else begin
                if (!keep) begin
                    zero_run_next = 2'd0;
                end else if (s_tdata == 8'h00) begin
                    zero_run_next = (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
                end else begin
                    zero_run_next = 2'd0;
                end
                if (keep && !s_tlast) begin
                    held_byte_next  = s_tdata;
                    held_valid_next = 1'b1;
                end
            end
            if (s_tlast) begin
                byte_pos_next   = 3'd0;
                hdr_size_next   = nud_pkg::HDR_LEN_BASE;
                zero_run_next   = 2'd0;
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
            end
        end
    end

    assign count_next = count_reg + (nud_pkg::QUEUE_AW + 1)'(push_cnt)
                      - (nud_pkg::QUEUE_AW + 1)'(out_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg   <= 3'd0;
            hdr_size_reg   <= nud_pkg::HDR_LEN_BASE;
            zero_run_reg   <= 2'd0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            hdr_byte_reg   <= 8'h00;
            ext_bit_reg    <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            byte_pos_reg   <= byte_pos_next;
            hdr_size_reg   <= hdr_size_next;
            zero_run_reg   <= zero_run_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            hdr_byte_reg   <= hdr_byte_next;
            ext_bit_reg    <= ext_bit_next;
            wr_ptr_reg     <= wr_ptr_reg + nud_pkg::QUEUE_AW'(push_cnt);
            rd_ptr_reg     <= rd_ptr_reg + nud_pkg::QUEUE_AW'(out_acc);
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_a) begin
            queue_mem[wr_ptr_reg] <= res_a;
        end
        if (push_b) begin
            queue_mem[wr_ptr_reg + nud_pkg::QUEUE_AW'(1)] <= res_b;
        end
    end

    assign m_tdata = queue_mem[rd_ptr_reg].payload_byte;
    assign m_tlast = queue_mem[rd_ptr_reg].payload_last;
    assign m_tuser = queue_mem[rd_ptr_reg].info;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (nud_pkg::QUEUE_AW + 1)'(nud_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_pair_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push_b |-> (push_a && s_tlast))
        else $error("two results from a byte that does not end the unit");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (byte_pos_reg == 3'd0 && zero_run_reg == 2'd0 && !held_valid_reg))
        else $error("unit state not restarted after unit end");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_pos_reg <= hdr_size_reg)
        else $error("header position ran past header size");

    a_hold_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_payload |-> !held_valid_reg)
        else $error("byte held back during header");

endmodule

FILE: tb/nud_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nud_stream_checker
// Watches both stream channels of the NAL unit deframer, predicts the
// payload transactions from each accepted input byte and compares every
// accepted output transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module nud_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // unit_end

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] payload_byte
    input  logic        m_tlast,   // payload_last
    input  logic [11:0] m_tuser,   // [1:0] ref_idc, [6:2] unit_type, [7] forbidden_bit,
                                   // [10:8] header_length, [11] extension_flag

    output int          mismatches,
    output int          outstanding
);

    logic [2:0] hdr_pos;
    logic [2:0] hdr_len;
    logic [1:0] zeros;
    logic [7:0] held;
    logic       held_ok;
    logic [7:0] hdr_byte;
    logic       ext_flag;

    nud_pkg::result_t payload_due[$];
    int               errors = 0;

    function automatic nud_pkg::result_t make_payload(input logic [7:0] b, input logic last);
        nud_pkg::result_t r;
        r.payload_byte        = b;
        r.payload_last        = last;
        r.info.ref_idc        = hdr_byte[6:5];
        r.info.unit_type      = hdr_byte[4:0];
        r.info.forbidden_bit  = hdr_byte[7];
        r.info.header_length  = hdr_len;
        r.info.extension_flag = ext_flag;
        return r;
    endfunction

    task automatic queue_due(input nud_pkg::result_t r);
        payload_due = {payload_due, r};
    endtask

    task automatic restart_unit();
        hdr_pos = '0;
        hdr_len = nud_pkg::HDR_LEN_BASE;
        zeros   = '0;
        held    = '0;
        held_ok = 1'b0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic last);
        logic keep;
        if (hdr_pos < hdr_len) begin
            if (hdr_pos == 3'd0) begin
                hdr_byte = b;
                ext_flag = 1'b0;
                if (b[4:0] == nud_pkg::NAL_TYPE_PREFIX || b[4:0] == nud_pkg::NAL_TYPE_SVC_EXT ||
                    b[4:0] == nud_pkg::NAL_TYPE_3DAVC_EXT) begin
                    hdr_len = nud_pkg::HDR_LEN_EXT;
                end else begin
                    hdr_len = nud_pkg::HDR_LEN_BASE;
                end
            end else if (hdr_pos == 3'd1) begin
                ext_flag = b[7];
                if (hdr_byte[4:0] == nud_pkg::NAL_TYPE_3DAVC_EXT && b[7]) begin
                    hdr_len = nud_pkg::HDR_LEN_3DAVC;
                end
            end
            hdr_pos = hdr_pos + 3'd1;
            if (last && held_ok) begin
                queue_due(make_payload(held, 1'b1));
            end
        end else begin
            keep = 1'b1;
            if (zeros == 2'd2 && b == nud_pkg::EMU_PREVENT_BYTE) begin
                keep  = 1'b0;
                zeros = '0;
            end else if (b == 8'h00) begin
                if (zeros != 2'd2) begin
                    zeros = zeros + 2'd1;
                end
            end else begin
                zeros = '0;
            end

            if (keep) begin
                if (held_ok) begin
                    queue_due(make_payload(held, 1'b0));
                end
                if (last) begin
                    queue_due(make_payload(b, 1'b1));
                    held_ok = 1'b0;
                end else begin
                    held    = b;
                    held_ok = 1'b1;
                end
            end else if (last && held_ok) begin
                queue_due(make_payload(held, 1'b1));
                held_ok = 1'b0;
            end
        end
        if (last) begin
            restart_unit();
        end
    endtask

    task automatic check_payload();
        nud_pkg::result_t   want;
        nud_pkg::hdr_info_t got;
        got = nud_pkg::hdr_info_t'(m_tuser);
        if (payload_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: unexpected transaction: byte %h last %b tuser %h",
                         $time, m_tdata, m_tlast, m_tuser);
            end
        end else begin
            want = payload_due.pop_front();
            if (want.payload_byte != m_tdata || want.payload_last != m_tlast ||
                want.info.ref_idc != got.ref_idc || want.info.unit_type != got.unit_type ||
                want.info.forbidden_bit != got.forbidden_bit ||
                want.info.header_length != got.header_length ||
                want.info.extension_flag != got.extension_flag) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: expected %h last %b user %h, got %h last %b user %h",
                             $time, want.payload_byte, want.payload_last, want.info,
                             m_tdata, m_tlast, m_tuser);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_unit();
            hdr_byte = '0;
            ext_flag = 1'b0;
            payload_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_payload();
            end
        end
        mismatches  <= errors;
        outstanding <= payload_due.size();
    end

endmodule

FILE: tb/tb_nal_unit_deframer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nal_unit_deframer_unit
// Drives NAL units into the deframer, directed ones first and then random
// units that are mostly well formed with emulation prevention sequences,
// under random stalls on both channels; the checker judges every transaction.
// ----------------------------------------------------------------------------
module tb_nal_unit_deframer_unit;

    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_AFTER   = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [11:0] m_tuser;

    int          mismatches;
    int          outstanding;
    int          cycles      = 0;
    int          items_sent  = 0;
    int          gap_odds    = 0;
    logic        calm        = 1'b0;
    logic [7:0]  unit_bytes[$];

    always #6 aclk = ~aclk;

    nal_unit_deframer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    nud_stream_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: bursts of back-pressure between runs of readiness
    initial begin
        int run;
        @(negedge aclk);
        forever begin
            if (calm || $urandom_range(0, 2) != 0) begin
                run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 20);
                m_tready <= 1'b1;
            end else begin
                run = $urandom_range(1, 13);
                m_tready <= 1'b0;
            end
            repeat (run) @(negedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (items_sent >= CALM_AFTER) begin
            calm = 1'b1;
        end
    endtask

    task automatic send_unit();
        int i;
        case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 3;
            default: gap_odds = 10;
        endcase
        for (i = 0; i < unit_bytes.size(); i++) begin
            send_byte(unit_bytes[i], i == unit_bytes.size() - 1);
        end
    endtask

    // hold the sender until every predicted transaction has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic append_byte(input logic [7:0] b);
        unit_bytes = {unit_bytes, b};
    endtask

    task automatic build_random_unit();
        int          kind;
        int          hdr;
        int          plen;
        int          i;
        logic [7:0]  second;
        logic [4:0]  nal_type;
        unit_bytes.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            plen = $urandom_range(1, 6);
            for (i = 0; i < plen; i++) begin
                append_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        case ($urandom_range(0, 5))
            0:       nal_type = nud_pkg::NAL_TYPE_PREFIX;
            1:       nal_type = nud_pkg::NAL_TYPE_SVC_EXT;
            2:       nal_type = nud_pkg::NAL_TYPE_3DAVC_EXT;
            default: nal_type = 5'($urandom_range(0, 31));
        endcase
        append_byte({$urandom_range(0, 7) == 0, 2'($urandom_range(0, 3)), nal_type});
        hdr = 1;
        if (nal_type == nud_pkg::NAL_TYPE_PREFIX || nal_type == nud_pkg::NAL_TYPE_SVC_EXT ||
            nal_type == nud_pkg::NAL_TYPE_3DAVC_EXT) begin
            second = 8'($urandom_range(0, 255));
            append_byte(second);
            hdr = (nal_type == nud_pkg::NAL_TYPE_3DAVC_EXT && second[7]) ? 3 : 4;
            for (i = 2; i < hdr; i++) begin
                append_byte(8'($urandom_range(0, 255)));
            end
        end
        // cut the unit short inside its header
        if (kind == 1) begin
            plen = (hdr > 1) ? $urandom_range(1, hdr - 1) : 1;
            while (unit_bytes.size() > plen) void'(unit_bytes.pop_back());
            return;
        end
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
        for (i = 0; i < plen; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: append_byte(8'h00);
                3:       append_byte(nud_pkg::EMU_PREVENT_BYTE);
                4: begin
                    append_byte(8'h00);
                    append_byte(8'h00);
                    append_byte(nud_pkg::EMU_PREVENT_BYTE);
                end
                default: append_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // forbidden bit set, three zeros before a dropped 03, ends on kept byte
        unit_bytes = {8'hE5, 8'h00, 8'h00, 8'h00, nud_pkg::EMU_PREVENT_BYTE, 8'hFF};
        send_unit();
        // prefix type with flag set keeps the four-byte header
        unit_bytes = {8'h0E, 8'h80, 8'h12, 8'h34, 8'hAB, 8'h00};
        send_unit();
        // 3d-avc type with flag set: three-byte header, ends on a dropped 03
        unit_bytes = {8'h75, 8'h80, 8'h01, 8'h00, 8'h00, nud_pkg::EMU_PREVENT_BYTE};
        send_unit();
        // 3d-avc type without flag, ends inside its header
        unit_bytes = {8'h15, 8'h7F, 8'h00};
        send_unit();
        // svc type ends on its first byte
        unit_bytes = {8'h14};
        send_unit();
        // lone 03 payload byte is kept
        unit_bytes = {8'h01, nud_pkg::EMU_PREVENT_BYTE};
        send_unit();
        wait_drained();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            build_random_unit();
            send_unit();
            if ($urandom_range(0, 39) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: nal_unit_deframer_unit.f
rtl/nud_pkg.sv
rtl/nal_unit_deframer_unit.sv
tb/nud_stream_checker.sv
tb/tb_nal_unit_deframer_unit.sv
